[design/mrq_pkg.sv]
package mrq_pkg;

  localparam int unsigned DistW     = 10;
  localparam int unsigned MoveW     = 8;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned DivW      = 14;
  localparam int unsigned DenW      = 8;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [DivW-1:0]    PeriodDividend = 14'd10000;
  localparam logic [6:0]         DistSat        = 7'd127;
  localparam logic [PeriodW-1:0] PeriodIdle     = 8'd255;

  typedef enum logic [2:0] {
    REG_RATE_LIMIT_ON     = 3'd0,
    REG_DPI_DIVIDE_ON     = 3'd1,
    REG_DPI_DIVISOR       = 3'd2,
    REG_BUFFER_LIMIT      = 3'd3,
    REG_RATE_FLOOR_PERIOD = 3'd4
  } reg_idx_e;

  localparam logic [2:0]         RstDivisor     = 3'd2;
  localparam logic [DistW-1:0]   RstBufferLimit = 10'd300;
  localparam logic [PeriodW-1:0] RstRateFloor   = 8'd6;

endpackage

[design/mouse_report_to_quadrature.sv]
// Converts mouse reports and prescaled timer ticks into quadrature and button pin levels,
// returning one result beat per input beat with the pin levels and pending distances. A
// tick beat updates the tick counters and quadrature levels on acceptance and then goes to
// the completion state. A report beat runs each axis with nonzero motion through one shared
// 14-step restoring divider: motion by the DPI divisor, then 10000 by the clamped distance,
// the second division being skipped when the distance clamps to zero. Each axis passes the
// setup state first. The completion state loads the output register. The block accepts no
// beat until the result of the previous one has been loaded into the output register,
// which a stalled output delays.
module mouse_report_to_quadrature
  import mrq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic signed [7:0] move_x_i,
  input  logic signed [7:0] move_y_i,
  input  logic [2:0]  button_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        x_a_o,
  output logic        x_b_o,
  output logic        y_a_o,
  output logic        y_b_o,
  output logic        left_pin_o,
  output logic        middle_pin_o,
  output logic        right_pin_o,
  output logic [9:0]  pending_x_o,
  output logic [9:0]  pending_y_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_MOV,
    ST_DIV_PER,
    ST_DONE
  } state_e;

  logic                 rate_on_q, div_on_q;
  logic [2:0]           divisor_q;
  logic [DistW-1:0]     buf_limit_q;
  logic [PeriodW-1:0]   rate_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_on_q    <= 1'b0;
      div_on_q     <= 1'b0;
      divisor_q    <= RstDivisor;
      buf_limit_q  <= RstBufferLimit;
      rate_floor_q <= RstRateFloor;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RATE_LIMIT_ON:     rate_on_q    <= cfg_wdata_i[0];
        REG_DPI_DIVIDE_ON:     div_on_q     <= cfg_wdata_i[0];
        REG_DPI_DIVISOR:       divisor_q    <= cfg_wdata_i[2:0];
        REG_BUFFER_LIMIT:      buf_limit_q  <= cfg_wdata_i[DistW-1:0];
        REG_RATE_FLOOR_PERIOD: rate_floor_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  state_e               state_q, state_d;
  logic                 ax_q, ax_d;
  logic [MoveW-1:0]     mx_q, mx_d, my_q, my_d;
  logic                 dir_q [2];
  logic                 dir_d [2];
  logic [1:0]           phase_q [2];
  logic [1:0]           phase_d [2];
  logic [DistW-1:0]     dist_q [2];
  logic [DistW-1:0]     dist_d [2];
  logic [PeriodW-1:0]   period_q [2];
  logic [PeriodW-1:0]   period_d [2];
  logic [PeriodW-1:0]   tick_q [2];
  logic [PeriodW-1:0]   tick_d [2];
  logic [3:0]           quad_q, quad_d;
  logic [2:0]           btn_q, btn_d;
  logic [DenW-1:0]      rem_q, rem_d, den_q, den_d;
  logic [DivW-1:0]      quo_q, quo_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [3:0]           out_quad_q, out_quad_d;
  logic [2:0]           out_btn_q, out_btn_d;
  logic [DistW-1:0]     out_px_q, out_px_d, out_py_q, out_py_d;

  logic                 in_fire;
  logic [DenW:0]        rem_sh, rem_sub;
  logic                 rem_ge;
  logic [DenW-1:0]      rem_nx;
  logic [DivW-1:0]      quo_nx;
  logic [MoveW-1:0]     m_cur, m_mag, mag_div;
  logic [2:0]           div_sel;
  logic [DistW:0]       dist_sum;
  logic [DistW-1:0]     dist_new;
  logic [6:0]           v_sat;
  logic [PeriodW-1:0]   per_raw, per_fin;
  logic                 div_last;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign rem_sh   = {rem_q, quo_q[DivW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_q};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign rem_nx   = rem_ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
  assign quo_nx   = {quo_q[DivW-2:0], rem_ge};
  assign div_last = cnt_q == DivCntW'(DivSteps - 1);
  assign m_cur    = ax_q ? my_q : mx_q;
  assign m_mag    = m_cur[MoveW-1] ? (~m_cur + 8'd1) : m_cur;
  assign div_sel  = (div_on_q && divisor_q != 3'd0) ? divisor_q : 3'd1;
  assign mag_div  = (quo_nx[MoveW-1:0] == '0) ? 8'd1 : quo_nx[MoveW-1:0];
  assign dist_sum = {1'b0, dist_q[ax_q]} + {3'b000, mag_div};
  assign dist_new = (dist_sum > {1'b0, buf_limit_q}) ? buf_limit_q : dist_sum[DistW-1:0];
  assign v_sat    = (dist_new > {3'b000, DistSat}) ? DistSat : dist_new[6:0];
  assign per_raw  = quo_nx[DivW-1:6] - 8'd1;
  assign per_fin  = (rate_on_q && per_raw < rate_floor_q) ? rate_floor_q : per_raw;

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    mx_d        = mx_q;
    my_d        = my_q;
    dir_d       = dir_q;
    phase_d     = phase_q;
    dist_d      = dist_q;
    period_d    = period_q;
    tick_d      = tick_q;
    quad_d      = quad_q;
    btn_d       = btn_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_quad_d  = out_quad_q;
    out_btn_d   = out_btn_q;
    out_px_d    = out_px_q;
    out_py_d    = out_py_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i) begin
            if (tick_q[0] != period_q[0]) begin
              tick_d[0] = tick_q[0] + 8'd1;
            end else begin
              tick_d[0] = '0;
              if (dist_q[0] != '0) begin
                case (phase_q[0])
                  2'd0:    quad_d[0] = 1'b1;
                  2'd1:    quad_d[1] = 1'b1;
                  2'd2:    quad_d[0] = 1'b0;
                  default: quad_d[1] = 1'b0;
                endcase
                phase_d[0] = phase_q[0] + (dir_q[0] ? 2'd1 : 2'd3);
                dist_d[0]  = dist_q[0] - 10'd1;
              end
            end
            if (tick_q[1] != period_q[1]) begin
              tick_d[1] = tick_q[1] + 8'd1;
            end else begin
              tick_d[1] = '0;
              if (dist_q[1] != '0) begin
                case (phase_q[1])
                  2'd3:    quad_d[2] = 1'b0;
                  2'd2:    quad_d[3] = 1'b0;
                  2'd1:    quad_d[2] = 1'b1;
                  default: quad_d[3] = 1'b1;
                endcase
                phase_d[1] = phase_q[1] + (dir_q[1] ? 2'd1 : 2'd3);
                dist_d[1]  = dist_q[1] - 10'd1;
              end
            end
            state_d = ST_DONE;
          end else begin
            mx_d  = move_x_i;
            my_d  = move_y_i;
            btn_d = ~button_bits_i;
            if (move_x_i != '0 && (!move_x_i[7]) != dir_q[0]) begin
              dist_d[0] = '0;
            end
            if (move_y_i != '0 && (!move_y_i[7]) != dir_q[1]) begin
              dist_d[1] = '0;
            end
            ax_d    = 1'b0;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (m_cur == '0) begin
          if (ax_q) begin
            state_d = ST_DONE;
          end else begin
            ax_d = 1'b1;
          end
        end else begin
          rem_d   = '0;
          quo_d   = {6'b000000, m_mag};
          den_d   = {5'b00000, div_sel};
          cnt_d   = '0;
          state_d = ST_DIV_MOV;
        end
      end
      ST_DIV_MOV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          dir_d[ax_q]  = !m_cur[MoveW-1];
          dist_d[ax_q] = dist_new;
          if (v_sat == '0) begin
            period_d[ax_q] = PeriodIdle;
            ax_d           = 1'b1;
            state_d        = ax_q ? ST_DONE : ST_SETUP;
          end else begin
            rem_d   = '0;
            quo_d   = PeriodDividend;
            den_d   = {1'b0, v_sat};
            cnt_d   = '0;
            state_d = ST_DIV_PER;
          end
        end
      end
      ST_DIV_PER: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          period_d[ax_q] = per_fin;
          ax_d           = 1'b1;
          state_d        = ax_q ? ST_DONE : ST_SETUP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_quad_d  = quad_q;
          out_btn_d   = btn_q;
          out_px_d    = dist_q[0];
          out_py_d    = dist_q[1];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= 1'b0;
      dir_q       <= '{1'b0, 1'b0};
      phase_q     <= '{2'd0, 2'd0};
      dist_q      <= '{'0, '0};
      period_q    <= '{'0, '0};
      tick_q      <= '{'0, '0};
      quad_q      <= '0;
      btn_q       <= 3'b111;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      dir_q       <= dir_d;
      phase_q     <= phase_d;
      dist_q      <= dist_d;
      period_q    <= period_d;
      tick_q      <= tick_d;
      quad_q      <= quad_d;
      btn_q       <= btn_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q       <= mx_d;
    my_q       <= my_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    out_quad_q <= out_quad_d;
    out_btn_q  <= out_btn_d;
    out_px_q   <= out_px_d;
    out_py_q   <= out_py_d;
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign x_a_o        = out_quad_q[0];
  assign x_b_o        = out_quad_q[1];
  assign y_a_o        = out_quad_q[2];
  assign y_b_o        = out_quad_q[3];
  assign left_pin_o   = out_btn_q[0];
  assign right_pin_o  = out_btn_q[1];
  assign middle_pin_o = out_btn_q[2];
  assign pending_x_o  = out_px_q;
  assign pending_y_o  = out_py_q;

  // The divider step count never runs past its last step while a division is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_MOV || state_q == ST_DIV_PER) |-> cnt_q <= DivCntW'(DivSteps - 1))
    else $error("divider step count out of range");

  // An accepted beat keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("block ready straight after accepting a beat");

  // A new result beat is only raised from the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside completion");

  // The divider only runs while a report is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_MOV || state_q == ST_DIV_PER) |-> in_stall_o && den_q != '0)
    else $error("divider running with a zero divisor or while ready");

endmodule

[test/mouse_report_to_quadrature_tb.sv]
`timescale 1ns / 1ps

module mouse_report_to_quadrature_tb;
  import mrq_pkg::*;

  localparam bit ReqReport = 1'b0;
  localparam bit ReqTick   = 1'b1;
  localparam int AxisX     = 0;
  localparam int AxisY     = 1;

  typedef struct packed {
    logic       x_a;
    logic       x_b;
    logic       y_a;
    logic       y_b;
    logic       left;
    logic       middle;
    logic       right;
    logic [9:0] pend_x;
    logic [9:0] pend_y;
  } pin_snapshot_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [2:0]        cfg_idx_i     = REG_RATE_LIMIT_ON;
  logic [9:0]        cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              req_type_i    = ReqReport;
  logic signed [7:0] move_x_i      = '0;
  logic signed [7:0] move_y_i      = '0;
  logic [2:0]        button_bits_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              x_a_o;
  logic              x_b_o;
  logic              y_a_o;
  logic              y_b_o;
  logic              left_pin_o;
  logic              middle_pin_o;
  logic              right_pin_o;
  logic [9:0]        pending_x_o;
  logic [9:0]        pending_y_o;

  mouse_report_to_quadrature dut (.*);

  // Mirror of the converter's settings and per-axis state.
  bit          rate_on      = 1'b0;
  bit          div_on       = 1'b0;
  logic [2:0]  divisor      = 3'd2;
  logic [9:0]  dist_cap     = 10'd300;
  logic [7:0]  rate_floor   = 8'd6;
  bit          heading [2]  = '{1'b0, 1'b0};
  logic [1:0]  phase [2]    = '{2'd0, 2'd0};
  int unsigned pending_dist [2] = '{0, 0};
  logic [7:0]  period [2]   = '{8'd0, 8'd0};
  logic [7:0]  tick_cnt [2] = '{8'd0, 8'd0};
  logic [3:0]  quad         = 4'b0000;
  logic [2:0]  buttons      = 3'b111;

  pin_snapshot_t expected_pins_q [$];
  int mismatches    = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int rx_stall_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void apply_motion(int axis, int motion);
    int d;
    int m;
    int unsigned mag;
    int unsigned v;
    int unsigned p;
    if (motion == 0) return;
    m = motion;
    d = (divisor == 3'd0) ? 1 : int'(divisor);
    if ((m > 0 && !heading[axis]) || (m < 0 && heading[axis])) pending_dist[axis] = 0;
    if (div_on) begin
      m = m / d;
      if (motion > 0 && m < 1) m = 1;
      if (motion < 0 && m > -1) m = -1;
    end
    heading[axis] = (motion > 0);
    mag = (m > 0) ? m : -m;
    pending_dist[axis] += mag;
    if (pending_dist[axis] > dist_cap) pending_dist[axis] = dist_cap;
    v = (pending_dist[axis] > 127) ? 127 : pending_dist[axis];
    if (v == 0) p = 255;
    else p = ((10000 / v) / 64) - 1;
    if (rate_on && p < rate_floor) p = rate_floor;
    period[axis] = p[7:0];
  endfunction

  function automatic void step_axis(int axis);
    if (tick_cnt[axis] != period[axis]) begin
      tick_cnt[axis] = tick_cnt[axis] + 8'd1;
      return;
    end
    tick_cnt[axis] = 8'd0;
    if (pending_dist[axis] == 0) return;
    if (axis == AxisX) begin
      case (phase[axis])
        2'd0: quad[0] = 1'b1;
        2'd1: quad[1] = 1'b1;
        2'd2: quad[0] = 1'b0;
        default: quad[1] = 1'b0;
      endcase
    end else begin
      case (phase[axis])
        2'd3: quad[2] = 1'b0;
        2'd2: quad[3] = 1'b0;
        2'd1: quad[2] = 1'b1;
        default: quad[3] = 1'b1;
      endcase
    end
    phase[axis] = heading[axis] ? phase[axis] + 2'd1 : phase[axis] - 2'd1;
    pending_dist[axis]--;
  endfunction

  function automatic pin_snapshot_t predict_pins(bit kind, logic signed [7:0] mx,
                                                 logic signed [7:0] my, logic [2:0] btn);
    pin_snapshot_t r;
    if (kind == ReqReport) begin
      apply_motion(AxisX, int'(mx));
      apply_motion(AxisY, int'(my));
      buttons = ~btn;
    end else begin
      step_axis(AxisX);
      step_axis(AxisY);
    end
    r.x_a    = quad[0];
    r.x_b    = quad[1];
    r.y_a    = quad[2];
    r.y_b    = quad[3];
    r.left   = buttons[0];
    r.right  = buttons[1];
    r.middle = buttons[2];
    r.pend_x = 10'(pending_dist[AxisX]);
    r.pend_y = 10'(pending_dist[AxisY]);
    return r;
  endfunction

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    pin_snapshot_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pins_q.size() == 0) begin
        mismatches++;
        $error("result beat with no expectation waiting");
      end else begin
        want = expected_pins_q.pop_front();
        check_field("x_a", 10'(want.x_a), 10'(x_a_o));
        check_field("x_b", 10'(want.x_b), 10'(x_b_o));
        check_field("y_a", 10'(want.y_a), 10'(y_a_o));
        check_field("y_b", 10'(want.y_b), 10'(y_b_o));
        check_field("left_pin", 10'(want.left), 10'(left_pin_o));
        check_field("middle_pin", 10'(want.middle), 10'(middle_pin_o));
        check_field("right_pin", 10'(want.right), 10'(right_pin_o));
        check_field("pending_x", want.pend_x, pending_x_o);
        check_field("pending_y", want.pend_y, pending_y_o);
      end
    end
  end

  always @(posedge clk_i) begin : drive_out_stall
    if (rx_stall_left == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
      rx_stall_left = $urandom_range(1, 16);
    if (rx_stall_left != 0) begin
      out_stall_i <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_beat(bit kind, logic signed [7:0] mx, logic signed [7:0] my,
                           logic [2:0] btn);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    move_x_i      <= mx;
    move_y_i      <= my;
    button_bits_i <= btn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pins_q.push_back(predict_pins(kind, mx, my, btn));
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(bit rate, bit divide, logic [2:0] dvsr, logic [9:0] cap,
                               logic [7:0] floor_p);
    wait_for_idle();
    write_reg(REG_RATE_LIMIT_ON, 10'(rate));
    write_reg(REG_DPI_DIVIDE_ON, 10'(divide));
    write_reg(REG_DPI_DIVISOR, 10'(dvsr));
    write_reg(REG_BUFFER_LIMIT, cap);
    write_reg(REG_RATE_FLOOR_PERIOD, 10'(floor_p));
    cfg_we_i   <= 1'b0;
    rate_on    = rate;
    div_on     = divide;
    divisor    = dvsr;
    dist_cap   = cap;
    rate_floor = floor_p;
  endtask

  function automatic logic signed [7:0] random_motion();
    case ($urandom_range(0, 3))
      0: return 8'sd0;
      1: return 8'(int'($urandom_range(0, 8)) - 4);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_reset_state();
    repeat (3) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
    push_beat(ReqReport, 8'sd0, 8'sd0, 3'd7);
    push_beat(ReqReport, 8'sd0, 8'sd0, 3'd0);
  endtask

  task automatic test_field_extremes();
    load_settings(1'b0, 1'b0, 3'd2, 10'd300, 8'd6);
    push_beat(ReqReport, 8'sd127, -8'sd128, 3'd5);
    repeat (4) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
    push_beat(ReqReport, -8'sd128, 8'sd127, 3'd2);
    push_beat(ReqReport, 8'sd1, -8'sd1, 3'd0);
    repeat (3) push_beat(ReqTick, -8'sd1, -8'sd1, 3'd7);
  endtask

  task automatic test_motion_division();
    load_settings(1'b0, 1'b1, 3'd0, 10'd300, 8'd6);
    push_beat(ReqReport, 8'sd5, -8'sd5, 3'd1);
    load_settings(1'b0, 1'b1, 3'd7, 10'd1023, 8'd6);
    push_beat(ReqReport, 8'sd3, -8'sd3, 3'd4);
    push_beat(ReqReport, -8'sd128, 8'sd127, 3'd3);
    repeat (2) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
  endtask

  task automatic test_zero_buffer_limit();
    load_settings(1'b0, 1'b0, 3'd1, 10'd0, 8'd6);
    push_beat(ReqReport, 8'sd127, -8'sd128, 3'd6);
    repeat (3) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
  endtask

  task automatic test_rate_floor();
    load_settings(1'b1, 1'b0, 3'd1, 10'd1023, 8'd255);
    push_beat(ReqReport, 8'sd127, 8'sd127, 3'd0);
    repeat (3) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
    load_settings(1'b1, 1'b1, 3'd1, 10'd1, 8'd0);
    push_beat(ReqReport, -8'sd1, -8'sd1, 3'd0);
    repeat (2) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
  endtask

  // A long period lets the counter climb, then a big move drops the period beneath it,
  // so the counter has to wrap before the axis fires again.
  task automatic test_period_wrap();
    load_settings(1'b0, 1'b0, 3'd1, 10'd300, 8'd6);
    push_beat(ReqReport, -8'sd1, -8'sd1, 3'd0);
    push_beat(ReqReport, 8'sd1, 8'sd1, 3'd0);
    while (tick_cnt[AxisX] < 8'd50) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
    push_beat(ReqReport, 8'sd127, 8'sd127, 3'd0);
    do push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0); while (tick_cnt[AxisX] != 8'd0);
    repeat (4) push_beat(ReqTick, 8'sd0, 8'sd0, 3'd0);
  endtask

  task automatic test_random_traffic();
    int tx_pct [7] = '{25, 10, 0, 40, 15, 5, 0};
    int rx_pct [7] = '{6, 3, 0, 12, 5, 2, 0};
    logic [9:0] cap;
    logic [7:0] floor_p;
    bit kind;
    for (int ph = 0; ph < 7; ph++) begin
      cap     = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 20))
                                            : 10'($urandom_range(1, 1023));
      floor_p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 20));
      case (ph)
        0: load_settings(1'b0, 1'b0, 3'd1, 10'd1, 8'd0);
        1: load_settings(1'b1, 1'b1, 3'd7, 10'd1023, 8'd255);
        default: load_settings(1'($urandom), 1'($urandom), 3'($urandom), cap, floor_p);
      endcase
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      for (int n = 0; n < 165; n++) begin
        kind = ($urandom_range(0, 99) < 65) ? ReqTick : ReqReport;
        push_beat(kind, random_motion(), random_motion(), 3'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 15;
    rx_idle_pct = 5;
    test_reset_state();
    test_field_extremes();
    test_motion_division();
    test_zero_buffer_limit();
    test_rate_floor();
    test_period_wrap();
    test_random_traffic();
    wait_for_idle();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
